// ----- hw/rtl/gha_pkg.sv -----
// shared types and constants of the generational handle allocator
// no dependencies; used by generational_handle_allocator_top
package gha_pkg;

  // port field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned HIDX_W  = 10;
  localparam int unsigned HGEN_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TDATA_W = 32;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CHECK = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

endpackage

// ----- hw/rtl/generational_handle_allocator_top.sv -----
// handle allocator with per-slot generations and a lifo free stack; needs gha_pkg, gha_ram
// a request goes from S_IDLE through S_POP (allocate from the stack only) to S_DONE, where its
// result is loaded into the output register once that is free; a new request is taken only in
// S_IDLE, after the read-then-write of the generation and stack rams via their single read ports
// reset: synchronous active-low rst_n clears table size, free count and control; ram contents
// are not cleared, entries are only read after they were written
module generational_handle_allocator_top #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned GEN_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [gha_pkg::TDATA_W-1:0]  in_tdata,   // [9:0] handle_index, [25:10] handle_generation
  input  logic [gha_pkg::REQ_W-1:0]    in_tuser,   // [1:0] req_type
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gha_pkg::TDATA_W-1:0]  out_tdata,  // [9:0] out_index, [25:10] out_generation
  output logic [gha_pkg::STAT_W-1:0]   out_tuser   // [1:0] status
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned GW    = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;
  localparam int unsigned CMP_W = CNT_W + gha_pkg::HIDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DONE
  } state_t;

  state_t state_r;

  // request held while it is worked on
  gha_pkg::req_t              req_r;
  logic [gha_pkg::HIDX_W-1:0] hidx_r;
  logic [gha_pkg::HGEN_W-1:0] hgen_r;
  logic                       pop_r;
  logic [IDX_W-1:0]           slot_r;

  // table bookkeeping
  logic [CNT_W-1:0] free_count_r;
  logic [CNT_W-1:0] table_size_r;

  // output register
  logic                         out_valid_r;
  logic [gha_pkg::HIDX_W-1:0]   out_index_r;
  logic [gha_pkg::HGEN_W-1:0]   out_gen_r;
  gha_pkg::status_t             out_status_r;

  // ram ports
  logic             gen_we, gen_re;
  logic [IDX_W-1:0] gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0] gen_wdata, gen_rdata;
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic                       accept;
  logic                       out_free;
  gha_pkg::req_t              in_req;
  logic [gha_pkg::HIDX_W-1:0] in_hidx;
  logic [IDX_W+gha_pkg::HIDX_W-1:0] in_addr_ext;
  logic [IDX_W-1:0]           in_addr;
  logic [IDX_W-1:0]           hidx_addr;
  logic [IDX_W+gha_pkg::HIDX_W-1:0] hidx_addr_ext;
  logic [CMP_W-1:0]           hidx_cmp, tsize_cmp;
  logic [GW+GEN_BITS-1:0]     stored_ext;
  logic [GW+gha_pkg::HGEN_W-1:0] hgen_ext;
  logic                       in_range, gen_match, handle_ok;
  logic                       stack_empty, table_full;
  logic [IDX_W+gha_pkg::HIDX_W-1:0] slot_out_ext, tsize_out_ext;

  assign in_req  = gha_pkg::req_t'(in_tuser);
  assign in_hidx = in_tdata[gha_pkg::HIDX_W-1:0];

  // only one request in flight; a finished result may still wait in the output register
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // index fields resized to the ram address width
  assign in_addr_ext   = {{IDX_W{1'b0}}, in_hidx};
  assign in_addr       = in_addr_ext[IDX_W-1:0];
  assign hidx_addr_ext = {{IDX_W{1'b0}}, hidx_r};
  assign hidx_addr     = hidx_addr_ext[IDX_W-1:0];

  // handle validity: index below the table size and generation equal to the stored one
  assign hidx_cmp   = {{CNT_W{1'b0}}, hidx_r};
  assign tsize_cmp  = {{gha_pkg::HIDX_W{1'b0}}, table_size_r};
  assign in_range   = hidx_cmp < tsize_cmp;
  assign stored_ext = {{GW{1'b0}}, gen_rdata};
  assign hgen_ext   = {{GW{1'b0}}, hgen_r};
  assign gen_match  = stored_ext[GW-1:0] == hgen_ext[GW-1:0];
  assign handle_ok  = in_range && gen_match;

  assign stack_empty = (free_count_r == '0);
  assign table_full  = (table_size_r == CNT_W'(SLOT_COUNT));

  assign slot_out_ext  = {{gha_pkg::HIDX_W{1'b0}}, slot_r};
  assign tsize_out_ext = {{gha_pkg::HIDX_W{1'b0}}, table_size_r[IDX_W-1:0]};

  // free stack already holds every slot
  function automatic logic table_full_stack();
    return free_count_r == CNT_W'(SLOT_COUNT);
  endfunction

  // read side: stack top on allocate, then the popped slot's generation;
  // the request's slot generation on free, check and the unused code
  always_comb begin
    stk_re    = accept && (in_req == gha_pkg::REQ_ALLOC) && !stack_empty;
    stk_raddr = IDX_W'(free_count_r - CNT_W'(1));
    gen_re    = (accept && (in_req != gha_pkg::REQ_ALLOC)) || (state_r == S_POP);
    gen_raddr = (state_r == S_POP) ? stk_rdata : in_addr;
  end

  // write side: only in the finishing cycle, when the result can be loaded
  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = hidx_addr;
    gen_wdata = gen_rdata + GEN_BITS'(1);
    stk_we    = 1'b0;
    stk_waddr = free_count_r[IDX_W-1:0];
    stk_wdata = hidx_addr;
    if (state_r == S_DONE && out_free) begin
      case (req_r)
        gha_pkg::REQ_ALLOC: begin
          // growing the table starts the new slot at generation zero
          if (!pop_r && !table_full) begin
            gen_we    = 1'b1;
            gen_waddr = table_size_r[IDX_W-1:0];
            gen_wdata = '0;
          end
        end
        gha_pkg::REQ_FREE: begin
          if (handle_ok && !table_full_stack()) begin
            gen_we = 1'b1;
            stk_we = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_count_r <= '0;
      table_size_r <= '0;
    end else begin
      // a result loaded in the finishing cycle keeps valid high
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r  <= in_req;
            hidx_r <= in_hidx;
            hgen_r <= in_tdata[gha_pkg::HIDX_W +: gha_pkg::HGEN_W];
            pop_r  <= (in_req == gha_pkg::REQ_ALLOC) && !stack_empty;
            // allocate from the stack needs a second read for the slot generation
            if ((in_req == gha_pkg::REQ_ALLOC) && !stack_empty) begin
              state_r <= S_POP;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_POP: begin
          slot_r  <= stk_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            case (req_r)
              gha_pkg::REQ_ALLOC: begin
                if (pop_r) begin
                  out_index_r  <= slot_out_ext[gha_pkg::HIDX_W-1:0];
                  out_gen_r    <= stored_ext[gha_pkg::HGEN_W-1:0];
                  out_status_r <= gha_pkg::ST_OK;
                  free_count_r <= free_count_r - CNT_W'(1);
                end else if (!table_full) begin
                  out_index_r  <= tsize_out_ext[gha_pkg::HIDX_W-1:0];
                  out_gen_r    <= '0;
                  out_status_r <= gha_pkg::ST_OK;
                  table_size_r <= table_size_r + CNT_W'(1);
                end else begin
                  out_index_r  <= '0;
                  out_gen_r    <= '0;
                  out_status_r <= gha_pkg::ST_FULL;
                end
              end
              gha_pkg::REQ_FREE: begin
                out_index_r <= hidx_r;
                out_gen_r   <= hgen_r;
                if (handle_ok && !table_full_stack()) begin
                  out_status_r <= gha_pkg::ST_OK;
                  free_count_r <= free_count_r + CNT_W'(1);
                end else begin
                  out_status_r <= gha_pkg::ST_STALE;
                end
              end
              default: begin
                // check, and the unused code, are read-only
                out_index_r  <= hidx_r;
                out_gen_r    <= hgen_r;
                out_status_r <= handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
              end
            endcase
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gha_pkg::TDATA_W - gha_pkg::HIDX_W - gha_pkg::HGEN_W){1'b0}},
                       out_gen_r, out_index_r};
  assign out_tuser  = out_status_r;

  // slot generations
  gha_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  // lifo of freed slot indices
  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// ----- hw/rtl/gha_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module gha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
